// File: sv/arpres_pkg.sv
// Shared types and constants of the single-entry ARP resolver.
`default_nettype none
package arpres_pkg;

	localparam int MAC_W   = 48;
	localparam int IP_W    = 32;
	localparam int CNT_W   = 16;
	localparam int RTRY_W  = 8;
	localparam int CFG_W   = 48;
	localparam int CFGIX_W = 3;

	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [15:0]       HW_TYPE_ETH   = 16'h0001;
	localparam logic [15:0]       PROTO_IPV4    = 16'h0800;
	localparam logic [7:0]        HW_LEN_ETH    = 8'd6;
	localparam logic [7:0]        PROTO_LEN_IP4 = 8'd4;
	localparam logic [15:0]       OPC_REQUEST   = 16'd1;
	localparam logic [15:0]       OPC_REPLY     = 16'd2;
	localparam logic [RTRY_W-1:0] RETRY_SPENT   = 8'hFF;

	typedef enum logic [1:0] {
		REQ_PACKET = 2'd0,
		REQ_TICK   = 2'd1,
		REQ_LOOKUP = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_FREE      = 2'd0,
		ST_RESOLVING = 2'd1,
		ST_OK        = 2'd2
	} entry_st_t;

	typedef enum logic [1:0] {
		SEND_NONE    = 2'd0,
		SEND_REQUEST = 2'd1,
		SEND_REPLY   = 2'd2
	} send_t;

	typedef enum logic [CFGIX_W-1:0] {
		CFG_OWN_IP          = 3'd0,
		CFG_OWN_MAC         = 3'd1,
		CFG_OK_TIMEOUT      = 3'd2,
		CFG_PENDING_TIMEOUT = 3'd3,
		CFG_MAX_RETRIES     = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CMD_NOP        = 3'd0,
		CMD_FILL       = 3'd1,
		CMD_FILL_REPLY = 3'd2,
		CMD_TICK       = 3'd3,
		CMD_LOOKUP     = 3'd4
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [MAC_W-1:0]  mac;
		logic [IP_W-1:0]   ip;
	} cmd_t;

	typedef struct packed {
		logic [IP_W-1:0]   own_ip;
		logic [CNT_W-1:0]  ok_timeout;
		logic [CNT_W-1:0]  pending_timeout;
		logic [RTRY_W-1:0] max_retries;
	} cfg_t;

	typedef struct packed {
		send_t             send;
		logic [MAC_W-1:0]  tmac;
		logic [IP_W-1:0]   tip;
		logic              hit;
		logic [MAC_W-1:0]  hmac;
		entry_st_t         status;
	} rsp_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage
`default_nettype wire

// File: sv/arpres_intf.sv
// Event and result channel interfaces of the ARP resolver.
`default_nettype none
interface arpres_evt_if;
	import arpres_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic              frame_complete;
	logic [15:0]       hw_type;
	logic [15:0]       proto_type;
	logic [7:0]        hw_len;
	logic [7:0]        proto_len;
	logic [15:0]       opcode;
	logic [MAC_W-1:0]  src_mac;
	logic [IP_W-1:0]   src_ip;
	logic [IP_W-1:0]   dst_ip;
	logic [IP_W-1:0]   lookup_ip;

	modport source (
		output valid, req_type, frame_complete, hw_type, proto_type, hw_len,
		       proto_len, opcode, src_mac, src_ip, dst_ip, lookup_ip,
		input  ready
	);
	modport sink (
		input  valid, req_type, frame_complete, hw_type, proto_type, hw_len,
		       proto_len, opcode, src_mac, src_ip, dst_ip, lookup_ip,
		output ready
	);
endinterface

interface arpres_rsp_if;
	import arpres_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        send_kind;
	logic [MAC_W-1:0]  arp_target_mac;
	logic [IP_W-1:0]   arp_target_ip;
	logic              hit;
	logic [MAC_W-1:0]  hit_mac;
	logic [1:0]        entry_status;

	modport source (
		output valid, send_kind, arp_target_mac, arp_target_ip, hit, hit_mac,
		       entry_status,
		input  ready
	);
	modport sink (
		input  valid, send_kind, arp_target_mac, arp_target_ip, hit, hit_mac,
		       entry_status,
		output ready
	);
endinterface
`default_nettype wire

// File: sv/arp_single_entry_resolver.sv
// Top level of the ARP resolver with a one-entry IP-to-MAC cache.
// Each event (ARP packet, timer tick or lookup) yields exactly one result, in order.
// The front end checks and classifies an event in the cycle it is accepted and
// writes it into a two-deep command queue; the entry engine takes one command
// per cycle while its result is not stalled, updates the entry and registers
// the result. Sustained rate is one event per cycle while results are taken.
// An accepted event is first written into its queue slot, and the result
// register loads when the engine pops that command. A stalled result holds
// the engine, and the event side stalls once both queue slots are taken. Own
// MAC is accepted on the configuration port and not used by any result field.
`default_nettype none
module arp_single_entry_resolver (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [arpres_pkg::CFGIX_W-1:0]    cfg_index,
	input  logic [arpres_pkg::CFG_W-1:0]      cfg_wdata,
	arpres_evt_if.sink                        evt,
	arpres_rsp_if.source                      rslt
);
	import arpres_pkg::*;

	cfg_t   cfg_q;
	cmd_t   push_cmd;
	cmd_t   head;
	qstat_t qstat;
	logic   push;
	logic   pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_ip          <= '0;
			cfg_q.ok_timeout      <= CNT_W'(5);
			cfg_q.pending_timeout <= CNT_W'(1);
			cfg_q.max_retries     <= RTRY_W'(3);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OWN_IP:          cfg_q.own_ip          <= cfg_wdata[IP_W-1:0];
				CFG_OK_TIMEOUT:      cfg_q.ok_timeout      <= cfg_wdata[CNT_W-1:0];
				CFG_PENDING_TIMEOUT: cfg_q.pending_timeout <= cfg_wdata[CNT_W-1:0];
				CFG_MAX_RETRIES:     cfg_q.max_retries     <= cfg_wdata[RTRY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	arpres_front u_front (
		.evt    (evt),
		.own_ip (cfg_q.own_ip),
		.qstat  (qstat),
		.push   (push),
		.cmd    (push_cmd)
	);

	arpres_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	arpres_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.rslt   (rslt)
	);

endmodule
`default_nettype wire

// File: sv/arpres_front.sv
// Front end: accepts events and classifies them into entry commands.
`default_nettype none
module arpres_front (
	arpres_evt_if.sink                 evt,
	input  logic [arpres_pkg::IP_W-1:0] own_ip,
	input  arpres_pkg::qstat_t          qstat,
	output logic                        push,
	output arpres_pkg::cmd_t            cmd
);
	import arpres_pkg::*;

	logic pkt_ok;

	assign evt.ready = !qstat.full;
	assign push      = evt.valid && !qstat.full;

	assign pkt_ok = evt.frame_complete
		&& (evt.hw_type == HW_TYPE_ETH) && (evt.hw_len == HW_LEN_ETH)
		&& (evt.proto_type == PROTO_IPV4) && (evt.proto_len == PROTO_LEN_IP4)
		&& ((evt.opcode == OPC_REQUEST) || (evt.opcode == OPC_REPLY))
		&& (evt.dst_ip == own_ip);

	always_comb begin
		cmd.op  = CMD_NOP;
		cmd.mac = evt.src_mac;
		cmd.ip  = evt.src_ip;
		unique case (evt.req_type)
			REQ_PACKET: begin
				if (pkt_ok) begin
					cmd.op = (evt.opcode == OPC_REQUEST) ? CMD_FILL_REPLY : CMD_FILL;
				end
			end
			REQ_TICK: begin
				cmd.op = CMD_TICK;
			end
			REQ_LOOKUP: begin
				cmd.op = CMD_LOOKUP;
				cmd.ip = evt.lookup_ip;
			end
			default: begin
				cmd.op = CMD_NOP;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: sv/arpres_queue.sv
// Command queue between the front end and the entry engine.
`default_nettype none
module arpres_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  arpres_pkg::cmd_t    push_cmd,
	input  logic                pop,
	output arpres_pkg::cmd_t    head,
	output arpres_pkg::qstat_t  qstat
);
	import arpres_pkg::*;

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign qstat.full  = (count_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign head        = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/arpres_back.sv
// Entry engine: runs queued commands against the cache entry and registers results.
`default_nettype none
module arpres_back (
	input  logic               clk,
	input  logic               arst_n,
	input  arpres_pkg::cfg_t   cfg,
	input  arpres_pkg::cmd_t   head,
	input  arpres_pkg::qstat_t qstat,
	output logic               pop,
	arpres_rsp_if.source       rslt
);
	import arpres_pkg::*;

	entry_st_t         st_q,  st_d;
	logic [IP_W-1:0]   ip_q,  ip_d;
	logic [MAC_W-1:0]  mac_q, mac_d;
	logic [CNT_W-1:0]  cd_q,  cd_d;
	logic [RTRY_W-1:0] rt_q,  rt_d;
	logic [CNT_W-1:0]  cd_dec;
	rsp_t              rsp_d;
	rsp_t              rsp_s1;
	logic              valid_s1;

	assign pop    = !qstat.empty && (!valid_s1 || rslt.ready);
	assign cd_dec = cd_q - CNT_W'(1);

	always_comb begin
		st_d  = st_q;
		ip_d  = ip_q;
		mac_d = mac_q;
		cd_d  = cd_q;
		rt_d  = rt_q;
		unique case (head.op) inside
			CMD_FILL, CMD_FILL_REPLY: begin
				st_d  = ST_OK;
				ip_d  = head.ip;
				mac_d = head.mac;
				cd_d  = cfg.ok_timeout;
				rt_d  = cfg.max_retries;
			end
			CMD_TICK: begin
				if (st_q != ST_FREE) begin
					cd_d = cd_dec;
					if (cd_dec == '0) begin
						if (st_q == ST_RESOLVING && rt_q == '0) begin
							rt_d = RETRY_SPENT;
							st_d = ST_FREE;
						end else begin
							if (st_q == ST_RESOLVING) begin
								rt_d = rt_q - RTRY_W'(1);
							end
							st_d = ST_RESOLVING;
							cd_d = cfg.pending_timeout;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rsp_d        = '0;
		rsp_d.send   = SEND_NONE;
		rsp_d.status = st_d;
		unique case (head.op) inside
			CMD_FILL_REPLY: begin
				rsp_d.send = SEND_REPLY;
				rsp_d.tmac = head.mac;
				rsp_d.tip  = head.ip;
			end
			CMD_TICK: begin
				if (st_q != ST_FREE && cd_dec == '0
					&& !(st_q == ST_RESOLVING && rt_q == '0)) begin
					rsp_d.send = SEND_REQUEST;
					rsp_d.tip  = ip_q;
				end
			end
			CMD_LOOKUP: begin
				if (st_q == ST_OK && ip_q == head.ip) begin
					rsp_d.hit  = 1'b1;
					rsp_d.hmac = mac_q;
				end else begin
					rsp_d.send = SEND_REQUEST;
					rsp_d.tip  = head.ip;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_FREE;
			ip_q     <= '0;
			mac_q    <= '0;
			cd_q     <= '0;
			rt_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (pop) begin
				st_q  <= st_d;
				ip_q  <= ip_d;
				mac_q <= mac_d;
				cd_q  <= cd_d;
				rt_q  <= rt_d;
			end
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (rslt.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_s1 <= rsp_d;
		end
	end

	assign rslt.valid          = valid_s1;
	assign rslt.send_kind      = 2'(rsp_s1.send);
	assign rslt.arp_target_mac = rsp_s1.tmac;
	assign rslt.arp_target_ip  = rsp_s1.tip;
	assign rslt.hit            = rsp_s1.hit;
	assign rslt.hit_mac        = rsp_s1.hmac;
	assign rslt.entry_status   = 2'(rsp_s1.status);

endmodule
`default_nettype wire

// File: sv/arpres_checker.sv
// Port-level checks on the resolver's result channel, bound to the top level.
`default_nettype none
module arpres_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          valid,
	input logic                          ready,
	input logic [1:0]                    send_kind,
	input logic [arpres_pkg::MAC_W-1:0]  arp_target_mac,
	input logic [arpres_pkg::IP_W-1:0]   arp_target_ip,
	input logic                          hit,
	input logic [arpres_pkg::MAC_W-1:0]  hit_mac,
	input logic [1:0]                    entry_status
);
	import arpres_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(send_kind) && $stable(arp_target_mac)
			&& $stable(arp_target_ip) && $stable(hit) && $stable(hit_mac)
			&& $stable(entry_status))
		else $error("result changed while stalled");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid && hit |-> send_kind == SEND_NONE && entry_status == ST_OK)
		else $error("hit without ok entry or with a send");

	a_reply_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid && send_kind == SEND_REPLY |-> entry_status == ST_OK && !hit)
		else $error("reply sent without a filled entry");

	a_tmac_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && send_kind != SEND_REPLY |-> arp_target_mac == '0)
		else $error("target mac set outside a reply");

endmodule

bind arp_single_entry_resolver arpres_checker u_arpres_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.valid          (rslt.valid),
	.ready          (rslt.ready),
	.send_kind      (rslt.send_kind),
	.arp_target_mac (rslt.arp_target_mac),
	.arp_target_ip  (rslt.arp_target_ip),
	.hit            (rslt.hit),
	.hit_mac        (rslt.hit_mac),
	.entry_status   (rslt.entry_status)
);
`default_nettype wire
